@@ sv/mns_pkg.sv @@
// Shared types and constants for the melody note sequencer.
package mns_pkg;

  localparam int unsigned MAX_NOTES_DEF = 256;
  localparam int unsigned LEN_W = 9;
  localparam int unsigned PTR_W = 9;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PROG_W = 24;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PLAY = 2'd1,
    KIND_STOP = 2'd2,
    KIND_LOAD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  load_index;
    logic [6:0]  load_note;
    logic [15:0] load_duration;
  } in_item_t;

  typedef struct packed {
    logic        onset;
    logic        tone_on;
    logic [6:0]  note_number;
    logic [15:0] note_duration_ms;
    logic [1:0]  run_state;
    logic [7:0]  position;
    logic [23:0] progress_ms;
    logic        finished;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  note;
    logic [15:0] duration;
  } entry_t;

endpackage

@@ sv/mns_song_mem.sv @@
// Song memory: one write port, one registered read port with write bypass.
module mns_song_mem #(
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  mns_pkg::entry_t    wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output mns_pkg::entry_t    rdata_o
);
  import mns_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // forward a write to the entry being read
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/melody_note_sequencer.sv @@
// Melody note sequencer top level: playback state, song memory and output skid.
//
// Takes one beat per clock cycle while not stalled. The song memory read port always
// fetches the entry after the current note, so a tick that ends a note finds the next
// entry already registered; the current entry and entry 0 are held in registers. No
// clearing pass after reset: the user must load entries before use (unchecked). An
// output register plus one skid stage let the input run while a result waits.
module melody_note_sequencer #(
  parameter int unsigned MAX_NOTES = mns_pkg::MAX_NOTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mns_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mns_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [mns_pkg::LEN_W-1:0]  cfg_wdata_i
);
  import mns_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_NOTES);

  logic              accept;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  len_d;
  mode_e             mode_q, mode_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d, ptr_nx;
  logic [TIME_W-1:0] time_q, time_d, time_inc;
  logic [PROG_W-1:0] comp_q, comp_d, comp_adv;
  logic [PROG_W:0]   comp_sum, prog_sum;
  entry_t            cur_q, cur_d;
  entry_t            entry0_q;
  entry_t            rd_entry;
  entry_t            onset_entry;
  logic              onset, finished, advance;
  logic              mem_we;
  logic [TIME_W-1:0] dur_sel, time_clamp;
  logic [PROG_W-1:0] progress;
  out_item_t         result;
  out_item_t         out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign accept = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Clamp the song length once, when it is written.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      len_d = LEN_W'(1);
    end else if (32'(cfg_wdata_i) > MAX_NOTES) begin
      len_d = LEN_W'(MAX_NOTES);
    end else begin
      len_d = cfg_wdata_i;
    end
  end

  assign mem_we = accept && (in_item_i.kind == KIND_LOAD) && (mode_q == MODE_STOPPED)
                  && (32'(in_item_i.load_index) < MAX_NOTES);

  assign time_inc = (time_q == '1) ? time_q : time_q + TIME_W'(1);
  assign comp_sum = {1'b0, comp_q} + (PROG_W + 1)'(cur_q.duration);
  assign comp_adv = comp_sum[PROG_W] ? '1 : comp_sum[PROG_W-1:0];

  always_comb begin
    mode_d      = mode_q;
    ptr_d       = ptr_q;
    time_d      = time_q;
    comp_d      = comp_q;
    cur_d       = cur_q;
    onset       = 1'b0;
    finished    = 1'b0;
    advance     = 1'b0;
    onset_entry = rd_entry;
    unique case (in_item_i.kind)
      KIND_TICK: begin
        if (mode_q == MODE_PLAYING) begin
          if (ptr_q >= len_q) begin
            mode_d = MODE_STOPPED;
            ptr_d  = '0;
            time_d = '0;
            comp_d = '0;
          end else if (time_inc >= cur_q.duration) begin
            if (ptr_q + PTR_W'(1) >= len_q) begin
              mode_d   = MODE_STOPPED;
              ptr_d    = '0;
              time_d   = '0;
              comp_d   = '0;
              finished = 1'b1;
            end else begin
              ptr_d   = ptr_q + PTR_W'(1);
              time_d  = '0;
              comp_d  = comp_adv;
              cur_d   = rd_entry;
              onset   = 1'b1;
              advance = 1'b1;
            end
          end else begin
            time_d = time_inc;
          end
        end
      end
      KIND_PLAY: begin
        unique case (mode_q)
          MODE_STOPPED: begin
            mode_d      = MODE_PLAYING;
            ptr_d       = '0;
            time_d      = '0;
            cur_d       = entry0_q;
            onset_entry = entry0_q;
            onset       = 1'b1;
          end
          MODE_PLAYING: mode_d = MODE_PAUSED;
          MODE_PAUSED:  mode_d = MODE_PLAYING;
          default:      mode_d = mode_q;
        endcase
      end
      KIND_STOP: begin
        mode_d = MODE_STOPPED;
        ptr_d  = '0;
        time_d = '0;
        comp_d = '0;
      end
      KIND_LOAD: begin
      end
      default: begin
      end
    endcase
  end

  // Progress: a note that just began adds no time of its own.
  assign dur_sel    = (ptr_q < len_q) ? cur_q.duration : entry0_q.duration;
  assign time_clamp = (time_d > dur_sel) ? dur_sel : time_d;
  assign prog_sum   = {1'b0, comp_q} + (PROG_W + 1)'(time_clamp);

  always_comb begin
    if (mode_d == MODE_STOPPED) begin
      progress = '0;
    end else if (advance) begin
      progress = comp_adv;
    end else begin
      progress = prog_sum[PROG_W] ? '1 : prog_sum[PROG_W-1:0];
    end
  end

  always_comb begin
    result                  = '0;
    result.onset            = onset;
    result.tone_on          = onset && (onset_entry.note != '0);
    result.note_number      = onset ? onset_entry.note : '0;
    result.note_duration_ms = onset ? onset_entry.duration : '0;
    result.run_state        = mode_d;
    result.position         = ptr_d[7:0];
    result.progress_ms      = progress;
    result.finished         = finished;
  end

  // Prefetch the entry after the pointer this cycle leaves.
  assign ptr_nx = accept ? ptr_d : ptr_q;

  mns_song_mem #(
    .Depth (MAX_NOTES)
  ) u_song_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(in_item_i.load_index)),
    .wdata_i ({in_item_i.load_note, in_item_i.load_duration}),
    .raddr_i (AddrW'(ptr_nx + PTR_W'(1))),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_W'(1);
      mode_q <= MODE_STOPPED;
      ptr_q  <= '0;
      time_q <= '0;
      comp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= len_d;
      end
      if (accept) begin
        mode_q <= mode_d;
        ptr_q  <= ptr_d;
        time_q <= time_d;
        comp_q <= comp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= cur_d;
    end
    if (mem_we && (in_item_i.load_index == '0)) begin
      entry0_q <= {in_item_i.load_note, in_item_i.load_duration};
    end
  end

  // Output register and skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_q <= result;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ sv/mns_checker.sv @@
// Port-level checks for the melody note sequencer, bound to the top level.
module mns_port_checks (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mns_pkg::out_item_t  out_item_o
);
  import mns_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // input backpressure only while a result waits
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_onset_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.onset |->
      (out_item_o.run_state == MODE_PLAYING) && !out_item_o.finished)
    else $error("onset outside playback");

  a_finish_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.finished |->
      (out_item_o.run_state == MODE_STOPPED) && (out_item_o.position == '0)
      && (out_item_o.progress_ms == '0))
    else $error("finish without rewind");

  a_tone_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.tone_on |->
      out_item_o.onset && (out_item_o.note_number != '0))
    else $error("tone on without audible onset");

endmodule

bind melody_note_sequencer mns_port_checks u_mns_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ test/mns_checker.sv @@
// Checker for the melody note sequencer: predicts each result and compares it.
module mns_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  mns_pkg::in_item_t         in_item_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  mns_pkg::out_item_t        out_item_i,
  input  logic                      cfg_we_i,
  input  logic [mns_pkg::LEN_W-1:0] cfg_wdata_i,
  output int                        err_count_o,
  output int                        waiting_o
);
  import mns_pkg::*;

  localparam int unsigned NOTES  = MAX_NOTES_DEF;
  localparam int unsigned TIME_MAX = 32'hFFFF;
  localparam int unsigned PROG_MAX = 32'hFF_FFFF;

  // Shadow of the song memory and the playback state
  logic [6:0]       note_mem [NOTES];
  logic [15:0]      dur_mem  [NOTES];
  logic [LEN_W-1:0] song_len;
  mode_e            play_mode;
  int unsigned      ptr;
  int unsigned      tin;
  int unsigned      done_ms;

  out_item_t        awaited_reports [$];
  out_item_t        want;
  int               errs;
  int               n_results;

  function automatic void rewind_player();
    play_mode = MODE_STOPPED;
    ptr       = 0;
    tin       = 0;
    done_ms   = 0;
  endfunction

  function automatic out_item_t step_player(input in_item_t b);
    out_item_t   r;
    int unsigned len;
    int unsigned dur;
    int unsigned cur;
    int unsigned t;
    int unsigned prog;
    logic        onset;
    logic        finished;
    onset    = 1'b0;
    finished = 1'b0;
    if (song_len == 0) len = 1;
    else if (song_len > NOTES) len = NOTES;
    else len = song_len;

    case (b.kind)
      KIND_TICK: begin
        if (play_mode == MODE_PLAYING) begin
          if (ptr >= len) begin
            // length was cut below the pointer: drop out silently
            rewind_player();
          end else begin
            dur = dur_mem[ptr];
            if (tin < TIME_MAX) tin++;
            if (tin >= dur) begin
              done_ms += dur;
              if (done_ms > PROG_MAX) done_ms = PROG_MAX;
              ptr++;
              tin = 0;
              if (ptr >= len) begin
                rewind_player();
                finished = 1'b1;
              end else begin
                onset = 1'b1;
              end
            end
          end
        end
      end
      KIND_PLAY: begin
        if (play_mode == MODE_STOPPED) begin
          if (ptr >= len) ptr = 0;
          play_mode = MODE_PLAYING;
          tin       = 0;
          onset     = 1'b1;
        end else if (play_mode == MODE_PLAYING) begin
          play_mode = MODE_PAUSED;
        end else begin
          play_mode = MODE_PLAYING;
        end
      end
      KIND_STOP: rewind_player();
      default: begin
        if (play_mode == MODE_STOPPED) begin
          note_mem[b.load_index] = b.load_note;
          dur_mem[b.load_index]  = b.load_duration;
        end
      end
    endcase

    prog = done_ms;
    if (play_mode == MODE_PLAYING || play_mode == MODE_PAUSED) begin
      cur = (ptr < len) ? ptr : 0;
      dur = dur_mem[cur];
      t   = (tin > dur) ? dur : tin;
      prog += t;
      if (prog > PROG_MAX) prog = PROG_MAX;
    end

    r.onset            = onset;
    r.tone_on          = onset && (note_mem[ptr[7:0]] != '0);
    r.note_number      = onset ? note_mem[ptr[7:0]] : '0;
    r.note_duration_ms = onset ? dur_mem[ptr[7:0]] : '0;
    r.run_state        = play_mode;
    r.position         = ptr[7:0];
    r.progress_ms      = prog[23:0];
    r.finished         = finished;
    return r;
  endfunction

  task automatic flag_error(input string what, input out_item_t exp_r, input out_item_t got_r);
    errs++;
    if (errs <= 10) begin
      $display("mns_checker: result %0d %s", n_results, what);
      $display("  exp onset=%0d tone=%0d note=%0d dur=%0d state=%0d pos=%0d prog=%0d fin=%0d",
               exp_r.onset, exp_r.tone_on, exp_r.note_number, exp_r.note_duration_ms,
               exp_r.run_state, exp_r.position, exp_r.progress_ms, exp_r.finished);
      $display("  got onset=%0d tone=%0d note=%0d dur=%0d state=%0d pos=%0d prog=%0d fin=%0d",
               got_r.onset, got_r.tone_on, got_r.note_number, got_r.note_duration_ms,
               got_r.run_state, got_r.position, got_r.progress_ms, got_r.finished);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (note_mem[i]) begin
        note_mem[i] = '0;
        dur_mem[i]  = '0;
      end
      song_len = LEN_W'(1);
      rewind_player();
      awaited_reports.delete();
      errs        = 0;
      n_results   = 0;
      err_count_o <= 0;
      waiting_o   <= 0;
    end else begin
      if (cfg_we_i) song_len = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) awaited_reports.push_back(step_player(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (awaited_reports.size() == 0) begin
          flag_error("with nothing expected", '0, out_item_i);
        end else begin
          want = awaited_reports.pop_front();
          if (out_item_i.onset            !== want.onset            ||
              out_item_i.tone_on          !== want.tone_on          ||
              out_item_i.note_number      !== want.note_number      ||
              out_item_i.note_duration_ms !== want.note_duration_ms ||
              out_item_i.run_state        !== want.run_state        ||
              out_item_i.position         !== want.position         ||
              out_item_i.progress_ms      !== want.progress_ms      ||
              out_item_i.finished         !== want.finished)
            flag_error("mismatch", want, out_item_i);
        end
        n_results++;
      end
      waiting_o   <= awaited_reports.size();
      err_count_o <= errs;
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the melody note sequencer: clock, reset, stimulus and verdict.
module tb;
  import mns_pkg::*;

  localparam int WATCHDOG = 1000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_we    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             quiet     = 1'b0;
  int               errs;
  int               waiting;
  int               idle_cycles = 0;
  int               burst_left  = 0;
  logic             stall_on    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  melody_note_sequencer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  mns_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .err_count_o (errs),
    .waiting_o   (waiting)
  );

  // Receiver: alternate stall bursts with free-running stretches
  always @(posedge clk) begin
    if (burst_left == 0) begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_on   = 1'b1;
        burst_left = $urandom_range(1, 15);
      end else begin
        stall_on   = 1'b0;
        burst_left = $urandom_range(1, 20);
      end
    end
    burst_left = burst_left - 1;
    out_stall <= stall_on;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input kind_e k, input logic [7:0] idx, input logic [6:0] nt,
                           input logic [15:0] dur);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{kind: k, load_index: idx, load_note: nt, load_duration: dur};
    do @(posedge clk); while (in_stall);
  endtask

  // Non-load beats carry random noise in the unused fields
  task automatic send_cmd(input kind_e k);
    send_beat(k, 8'($urandom), 7'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [LEN_W-1:0] len_v;
    int               pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every entry with short notes so any length reads written entries only
    for (int i = 0; i < 256; i++)
      send_beat(KIND_LOAD, 8'(i),
                ($urandom_range(0, 5) == 0) ? 7'd0 : 7'($urandom_range(1, 127)),
                16'($urandom_range(0, 1)));

    // Directed: rest with zero duration, extreme entry, pause/resume, ignored load
    set_length(LEN_W'(4));
    send_beat(KIND_LOAD, 8'd0, 7'd0, 16'd0);
    send_beat(KIND_LOAD, 8'd1, 7'd127, 16'hFFFF);
    send_beat(KIND_LOAD, 8'd2, 7'd60, 16'd2);
    send_beat(KIND_LOAD, 8'd3, 7'd1, 16'd1);
    send_cmd(KIND_TICK);
    send_cmd(KIND_STOP);
    send_cmd(KIND_PLAY);
    send_cmd(KIND_TICK);
    send_cmd(KIND_TICK);
    send_cmd(KIND_TICK);
    send_cmd(KIND_PLAY);
    send_cmd(KIND_TICK);
    send_cmd(KIND_PLAY);
    send_beat(KIND_LOAD, 8'd2, 7'd33, 16'd9);
    send_cmd(KIND_STOP);
    // replace the long entry, then cut the length under a paused pointer
    send_beat(KIND_LOAD, 8'd1, 7'd64, 16'd1);
    send_cmd(KIND_PLAY);
    send_cmd(KIND_TICK);
    send_cmd(KIND_TICK);
    send_cmd(KIND_PLAY);
    set_length(LEN_W'(0));
    send_cmd(KIND_PLAY);
    send_cmd(KIND_TICK);
    // play a three-note song through to its end
    set_length(LEN_W'(3));
    send_cmd(KIND_PLAY);
    repeat (4) send_cmd(KIND_TICK);

    // Whole memory; every note but entry 2 lasts one tick at most
    set_length(LEN_W'(511));
    send_cmd(KIND_PLAY);
    repeat (262) send_cmd(KIND_TICK);

    for (int p = 0; p < 8; p++) begin
      if (p == 6) quiet <= 1'b1;
      case (p)
        0:       len_v = LEN_W'(256);
        1:       len_v = LEN_W'(1);
        2:       len_v = LEN_W'($urandom_range(257, 511));
        3:       len_v = LEN_W'(0);
        default: len_v = LEN_W'($urandom_range(1, 40));
      endcase
      set_length(len_v);
      send_cmd(KIND_PLAY);
      repeat (70) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) send_cmd(KIND_TICK);
        else if (pick < 72) send_cmd(KIND_PLAY);
        else if (pick < 78) send_cmd(KIND_STOP);
        else
          send_beat(KIND_LOAD, 8'($urandom), 7'($urandom),
                    ($urandom_range(0, 24) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 6)));
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
